[rtl/wsg_pkg.sv]
// Waveform sample generator: shared constants, types and the quarter-wave sine table builder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package wsg_pkg;

	localparam int PHASE_BITS      = 16;
	localparam int SINE_TABLE_BITS = 10;
	localparam int MAX_RESOLUTION  = 16;

	localparam int FUNC_W   = 3;
	localparam int SAMPLE_W = 16;
	localparam int AMP_W    = 16;
	localparam int OFS_W    = 17;
	localparam int RES_W    = 5;
	localparam int CFG_W    = 17;
	localparam int IDX_W    = 2;

	localparam int Q14_BITS = 14;
	localparam int WAVE_W   = Q14_BITS + 2;             // signed, -1.0 .. +1.0
	localparam int ROM_W    = Q14_BITS + 1;             // unsigned, 0 .. 1.0
	localparam int ROM_AW   = SINE_TABLE_BITS + 1;
	localparam int ROM_DEPTH = (1 << SINE_TABLE_BITS) + 1;
	localparam int PROD_W   = WAVE_W + AMP_W + 1;
	localparam int SUM_W    = PROD_W + 1;
	localparam int LEVEL_W  = 2 * Q14_BITS + 2;         // 0 .. 2^29
	localparam int SCALED_W = LEVEL_W + MAX_RESOLUTION;
	localparam int IN_W     = ((FUNC_W + PHASE_BITS + 7) / 8) * 8;

	localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(16384);
	localparam logic [OFS_W-1:0] OFS_RESET = '0;
	localparam logic [RES_W-1:0] RES_RESET = RES_W'(12);

	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

	typedef logic signed [WAVE_W-1:0] wave_t;
	typedef logic [ROM_W-1:0] sine_rom_t [ROM_DEPTH];

	typedef enum logic [FUNC_W-1:0] {
		FUNC_SINE     = 3'd0,
		FUNC_SQUARE   = 3'd1,
		FUNC_TRIANGLE = 3'd2,
		FUNC_SAWTOOTH = 3'd3,
		FUNC_NOISE    = 3'd4
	} func_t;

	typedef enum logic [IDX_W-1:0] {
		REG_AMPLITUDE  = 2'd0,
		REG_DC_OFFSET  = 2'd1,
		REG_RESOLUTION = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [AMP_W-1:0]        amplitude;
		logic signed [OFS_W-1:0] dc_offset;
		logic [RES_W-1:0]        resolution;
	} cfg_t;

	typedef struct packed {
		logic  valid;
		wave_t value;
	} wave_word_t;

	typedef struct packed {
		logic                valid;
		logic [SAMPLE_W-1:0] sample;
	} sample_word_t;

	// Entry k = round(16384 * sin(pi/2 * k / 2^SINE_TABLE_BITS)), Taylor series in Q30.
	// Evaluated at elaboration only.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t         rom;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic signed [63:0] r;
		for (int k = 0; k < ROM_DEPTH; k++) begin
			x    = (PI_HALF_Q30 * 64'(k)) >> SINE_TABLE_BITS;
			x2   = (x * x) >> 30;
			term = x;
			sum  = $signed(x);
			for (int i = 1; i <= 8; i++) begin
				term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
				if (i % 2 == 1) begin
					sum = sum - $signed(term);
				end else begin
					sum = sum + $signed(term);
				end
			end
			if (sum < 0) begin
				sum = '0;
			end
			r = (sum + 64'sd32768) >>> 16;
			if (r > 64'sd16384) begin
				r = 64'sd16384;
			end
			rom[k] = ROM_W'(r);
		end
		return rom;
	endfunction

endpackage

`default_nettype wire

[rtl/wsg_wave.sv]
// Wave value stages s1..s2: quarter-wave ROM lookup, square, triangle, sawtooth; other codes give 0.
// Depends on wsg_pkg.
`default_nettype none

module wsg_wave import wsg_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  in_valid,
	input  wire logic [FUNC_W-1:0]     func,
	input  wire logic [PHASE_BITS-1:0] phase,
	output wave_word_t                 wave
);

	localparam int OFF_W   = PHASE_BITS - 2;
	localparam int SH      = PHASE_BITS - 2 - SINE_TABLE_BITS;
	localparam int SHR     = (SH >= 0) ? SH : 0;
	localparam int SHL     = (SH < 0) ? -SH : 0;
	localparam int EXT_W   = OFF_W + SINE_TABLE_BITS;
	localparam int RAMP_W  = PHASE_BITS + Q14_BITS + 2;
	localparam logic [ROM_AW-1:0] QUARTER_IDX = ROM_AW'(1 << SINE_TABLE_BITS);
	localparam logic [PHASE_BITS-1:0] QUARTER  = PHASE_BITS'(1 << (PHASE_BITS - 2));
	localparam logic [PHASE_BITS-1:0] QUARTER3 = PHASE_BITS'(3 << (PHASE_BITS - 2));
	localparam wave_t ONE = WAVE_W'(1 << Q14_BITS);

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	func_t                     fsel;
	logic [1:0]                quad;
	logic [EXT_W-1:0]          off_ext;
	logic [SINE_TABLE_BITS-1:0] idx;
	logic [ROM_AW-1:0]         addr;
	logic [PHASE_BITS-1:0]     tri_d;
	logic [RAMP_W-1:0]         tri_ramp;
	logic [RAMP_W-1:0]         saw_ramp;
	wave_t                     alt;

	logic                      valid_s1;
	logic                      sine_s1;
	logic                      neg_s1;
	logic [ROM_W-1:0]          rom_s1;
	wave_t                     alt_s1;
	logic                      valid_s2;
	wave_t                     wave_s2;

	always_comb begin
		fsel    = func_t'(func);
		quad    = phase[PHASE_BITS-1 -: 2];
		off_ext = EXT_W'(phase[OFF_W-1:0]);
		idx     = SINE_TABLE_BITS'((off_ext >> SHR) << SHL);
		addr    = quad[0] ? (QUARTER_IDX - ROM_AW'(idx)) : ROM_AW'(idx);
	end

	// 4*d/P in Q14 and 2*p/P in Q14, floor
	always_comb begin
		unique case (quad)
			2'd0:    tri_d = phase;
			2'd3:    tri_d = phase - QUARTER3;
			default: tri_d = phase - QUARTER;
		endcase
		tri_ramp = (RAMP_W'(tri_d) << (Q14_BITS + 2)) >> PHASE_BITS;
		saw_ramp = (RAMP_W'(phase) << (Q14_BITS + 1)) >> PHASE_BITS;
	end

	always_comb begin
		unique case (fsel)
			FUNC_SQUARE:   alt = phase[PHASE_BITS-1] ? -ONE : ONE;
			FUNC_TRIANGLE: begin
				unique case (quad)
					2'd0:    alt = WAVE_W'(tri_ramp);
					2'd3:    alt = -ONE + WAVE_W'(tri_ramp);
					default: alt = ONE - WAVE_W'(tri_ramp);
				endcase
			end
			FUNC_SAWTOOTH: alt = WAVE_W'(saw_ramp) - ONE;
			default:       alt = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rom_s1  <= SINE_ROM[addr];
			sine_s1 <= (fsel == FUNC_SINE);
			neg_s1  <= quad[1];
			alt_s1  <= alt;
			if (sine_s1) begin
				wave_s2 <= neg_s1 ? -WAVE_W'(rom_s1) : WAVE_W'(rom_s1);
			end else begin
				wave_s2 <= alt_s1;
			end
		end
	end

	assign wave.valid = valid_s2;
	assign wave.value = wave_s2;

endmodule

`default_nettype wire

[rtl/wsg_scale.sv]
// Scaling stages s3..s5: gain, offset and clamp to [0,1], then scale to the DAC full-scale code.
// Depends on wsg_pkg.
`default_nettype none

module wsg_scale import wsg_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire wave_word_t wave,
	input  wire cfg_t       cfg,
	output sample_word_t    result
);

	localparam logic signed [SUM_W-1:0] HALF_LEVEL = SUM_W'(1 << (2 * Q14_BITS));
	localparam logic signed [SUM_W-1:0] FULL_LEVEL = SUM_W'(1 << (2 * Q14_BITS + 1));
	localparam logic [RES_W-1:0] RES_SAT = RES_W'(MAX_RESOLUTION);

	logic [RES_W-1:0]            res_sat;
	logic [MAX_RESOLUTION:0]     full_scale;
	logic [MAX_RESOLUTION-1:0]   maxv;
	logic signed [SUM_W-1:0]     ofs_scaled;
	logic signed [SUM_W-1:0]     sum;

	logic                        valid_s3;
	logic signed [PROD_W-1:0]    prod_s3;
	logic                        valid_s4;
	logic [LEVEL_W-1:0]          level_s4;
	logic                        valid_s5;
	logic [SCALED_W-1:0]         scaled_s5;

	always_comb begin
		res_sat    = (cfg.resolution > RES_SAT) ? RES_SAT : cfg.resolution;
		full_scale = ((MAX_RESOLUTION + 1)'(1) << res_sat) - (MAX_RESOLUTION + 1)'(1);
		maxv       = full_scale[MAX_RESOLUTION-1:0];
		ofs_scaled = SUM_W'(cfg.dc_offset) <<< Q14_BITS;
		sum        = SUM_W'(prod_s3) + ofs_scaled + HALF_LEVEL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s3 <= wave.valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= PROD_W'(wave.value) * $signed({1'b0, cfg.amplitude});
			if (sum < 0) begin
				level_s4 <= '0;
			end else if (sum > FULL_LEVEL) begin
				level_s4 <= LEVEL_W'(FULL_LEVEL);
			end else begin
				level_s4 <= LEVEL_W'(sum);
			end
			scaled_s5 <= SCALED_W'(level_s4) * SCALED_W'(maxv);
		end
	end

	assign result.valid  = valid_s5;
	assign result.sample = scaled_s5[LEVEL_W-1 +: SAMPLE_W];

endmodule

`default_nettype wire

[rtl/wsg_skid.sv]
// Output register with one skid entry; the pipeline advances only while the skid entry is empty.
// Depends on wsg_pkg.
`default_nettype none

module wsg_skid import wsg_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sample_word_t         result,
	output logic                      en,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [SAMPLE_W-1:0]       m_tdata
);

	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_data_q;
	logic                skid_valid_q;
	logic [SAMPLE_W-1:0] skid_data_q;
	logic                pop;
	logic                push;

	assign en   = !skid_valid_q;
	assign pop  = out_valid_q && m_tready;
	assign push = en && result.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= push;
				end
			end else if (push) begin
				if (out_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (push) begin
				out_data_q <= result.sample;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_data_q <= result.sample;
			end else begin
				out_data_q <= result.sample;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

[rtl/waveform_sample_generator.sv]
// Waveform sample generator top level: config registers, wave stages, scale stages, output skid.
// Depends on wsg_pkg, wsg_wave, wsg_scale and wsg_skid.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  s_tdata: func[2:0], phase[18:3], zero[23:19]
//  m_*       out        m_tvalid / m_tready  m_tdata: sample[15:0]
//  cfg_*     in         cfg_we               cfg_index, cfg_data[16:0]
//
// One word per cycle sustained while the output is not stalled; five pipeline stages plus
// the output register, so a word passes s1 to s5 and the output register before it shows
// on m_tvalid. s1 holds the sine ROM read, s3 the gain multiply, s5 the full-scale multiply.
// Reset clears all valid bits and loads amplitude 1.0, offset 0, resolution 12.
// A stall at the output fills the skid entry; s_tready then drops and the whole pipeline holds.
`default_nettype none

module waveform_sample_generator import wsg_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [IN_W-1:0]     s_tdata,   // func[2:0], phase[18:3]
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [SAMPLE_W-1:0]      m_tdata,   // sample[15:0]
	input  wire logic                cfg_we,
	input  wire logic [IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_W-1:0]    cfg_data
);

	cfg_t         cfg_q;
	logic         en;
	wave_word_t   wave;
	sample_word_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.amplitude  <= AMP_RESET;
			cfg_q.dc_offset  <= OFS_RESET;
			cfg_q.resolution <= RES_RESET;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_AMPLITUDE:  cfg_q.amplitude  <= cfg_data[AMP_W-1:0];
				REG_DC_OFFSET:  cfg_q.dc_offset  <= cfg_data[OFS_W-1:0];
				REG_RESOLUTION: cfg_q.resolution <= cfg_data[RES_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready = en;

	wsg_wave u_wave (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.func     (s_tdata[FUNC_W-1:0]),
		.phase    (s_tdata[FUNC_W +: PHASE_BITS]),
		.wave     (wave)
	);

	wsg_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.wave   (wave),
		.cfg    (cfg_q),
		.result (result)
	);

	wsg_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.result   (result),
		.en       (en),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

[rtl/wsg_checker.sv]
// Port-level checks for the waveform sample generator, bound to the top level.
// Depends on wsg_pkg and waveform_sample_generator.
`default_nettype none

module wsg_checker import wsg_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [SAMPLE_W-1:0] m_tdata
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// input backpressure only follows an output stall
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> $past(m_tvalid && !m_tready))
		else $error("s_tready low without output stall");

	// skid entry in use implies a waiting output word
	a_skid_out: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("s_tready low with empty output");

	// a word taken with the pipeline flowing reaches the output after the pipeline depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 s_tready ##1 s_tready ##1 s_tready ##1 s_tready
		##1 s_tready |=> m_tvalid)
		else $error("word lost in pipeline");

endmodule

bind waveform_sample_generator wsg_checker u_wsg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
